// ----- src/double_ended_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared concurrent assertion forms used by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DEQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Field widths, command and status codes, and the response control bundle.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int CMD_W    = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Tells the output register what to capture this cycle.
   typedef struct packed {
      logic                load;
      logic                from_mem;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_ctl_type;

endpackage

// ----- src/deq_if.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue channels
// Valid/ready channel interfaces for commands and results.
// ----------------------------------------------------------------------------
interface deq_req_if
   import deq_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic signed [DATA_W-1:0] value_in;

   modport source (output valid, cmd, value_in, input ready);
   modport sink   (input valid, cmd, value_in, output ready);
endinterface

interface deq_rsp_if
   import deq_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value_out;
   logic [STATUS_W-1:0]      status;
   logic                     last;

   modport source (output valid, value_out, status, last, input ready);
   modport sink   (input valid, value_out, status, last, output ready);
endinterface

// ----- src/deq_ram.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue element store
// One write port and one registered read port; read data holds between reads.
// ----------------------------------------------------------------------------
module deq_ram
   import deq_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Ring pointers, element count and the command sequencer that drives the store.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module deq_ctrl
   import deq_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [DATA_W-1:0] req_value,
   output logic              req_ready,
   input  logic              out_free,
   output logic              wr_en,
   output logic [IDX_W-1:0]  wr_addr,
   output logic [DATA_W-1:0] wr_data,
   output logic              rd_en,
   output logic [IDX_W-1:0]  rd_addr,
   output rsp_ctl_type       rsp_ctl
);

   localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W:0]   DEPTH_S  = (CNT_W + 1)'(DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_POP, S_DUMP} state_type;

   state_type        state_ff,     state_in;
   logic [IDX_W-1:0] front_ff,     front_in;
   logic [CNT_W-1:0] count_ff,     count_in;
   logic [IDX_W-1:0] dump_ptr_ff,  dump_ptr_in;
   logic [CNT_W-1:0] dump_left_ff, dump_left_in;

   logic [CNT_W:0]   tail_sum;
   logic [IDX_W-1:0] tail_pos;
   logic [IDX_W-1:0] back_pos;
   logic             full;
   logic             empty;
   logic             accept;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] a);
      return (a == IDX_MAX) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] a);
      return (a == '0) ? IDX_MAX : a - 1'b1;
   endfunction

   // Slot just past the back element; the back element sits one before it.
   assign tail_sum = {1'b0, CNT_W'(front_ff)} + {1'b0, count_ff};
   assign tail_pos = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);
   assign back_pos = prev_idx(tail_pos);
   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);

   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      dump_ptr_in  = dump_ptr_ff;
      dump_left_in = dump_left_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_pos;
      wr_data      = req_value;
      rd_en        = 1'b0;
      rd_addr      = front_ff;
      rsp_ctl      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_PUSH_BACK: begin
                     rsp_ctl.load = 1'b1;
                     rsp_ctl.last = 1'b1;
                     if (full) begin
                        rsp_ctl.status = ST_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        count_in       = count_ff + 1'b1;
                        rsp_ctl.status = ST_OK;
                     end
                  end
                  CMD_PUSH_FRONT: begin
                     rsp_ctl.load = 1'b1;
                     rsp_ctl.last = 1'b1;
                     if (full) begin
                        rsp_ctl.status = ST_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        wr_addr        = prev_idx(front_ff);
                        front_in       = prev_idx(front_ff);
                        count_in       = count_ff + 1'b1;
                        rsp_ctl.status = ST_OK;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (empty) begin
                        rsp_ctl.load   = 1'b1;
                        rsp_ctl.last   = 1'b1;
                        rsp_ctl.status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        front_in = next_idx(front_ff);
                        count_in = count_ff - 1'b1;
                        state_in = S_POP;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (empty) begin
                        rsp_ctl.load   = 1'b1;
                        rsp_ctl.last   = 1'b1;
                        rsp_ctl.status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = back_pos;
                        count_in = count_ff - 1'b1;
                        state_in = S_POP;
                     end
                  end
                  CMD_DUMP: begin
                     if (empty) begin
                        rsp_ctl.load   = 1'b1;
                        rsp_ctl.last   = 1'b1;
                        rsp_ctl.status = ST_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        dump_ptr_in  = next_idx(front_ff);
                        dump_left_in = count_ff;
                        state_in     = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            // The output register was free when the pop was taken.
            rsp_ctl.load     = 1'b1;
            rsp_ctl.from_mem = 1'b1;
            rsp_ctl.status   = ST_OK;
            rsp_ctl.last     = 1'b1;
            state_in         = S_IDLE;
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_ctl.load     = 1'b1;
               rsp_ctl.from_mem = 1'b1;
               rsp_ctl.status   = ST_OK;
               rsp_ctl.last     = (dump_left_ff == CNT_W'(1));
               if (dump_left_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  // Fetch the next element while this one goes out.
                  rd_en        = 1'b1;
                  rd_addr      = dump_ptr_ff;
                  dump_ptr_in  = next_idx(dump_ptr_ff);
                  dump_left_in = dump_left_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         dump_ptr_ff  <= '0;
         dump_left_ff <= '0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         dump_ptr_ff  <= dump_ptr_in;
         dump_left_ff <= dump_left_in;
      end
   end

   `DEQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL,
      "element count exceeds the ring depth")
   `DEQ_ASSERT_NEXT(a_push_grows, clock, reset,
      accept && !full && (req_cmd == CMD_PUSH_BACK || req_cmd == CMD_PUSH_FRONT),
      count_ff == CNT_W'($past(count_ff) + 1'b1),
      "accepted push did not grow the queue by one")
   `DEQ_ASSERT_IMPL(a_dump_nonzero, clock, reset, state_ff == S_DUMP,
      dump_left_ff != '0 && dump_left_ff <= count_ff,
      "dump remainder out of range")
   `DEQ_ASSERT_IMPL(a_load_free, clock, reset, rsp_ctl.load, out_free,
      "result loaded while the output register is occupied")

endmodule

// ----- src/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue (top level)
// A push, a rejected command or an empty status goes straight to the output
// register; a popped value or a dumped element first passes the store's
// registered read port. Pushes are taken one item per cycle while the sink
// keeps up; a pop or a dump holds off new commands until its last result is
// loaded, and a dump sends one element per cycle while the sink keeps up.
// Reset (synchronous) empties the queue; the element store keeps stale data.
// ----------------------------------------------------------------------------
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   deq_req_if.sink    req_chan,
   deq_rsp_if.source  rsp_chan
);

   // Ring index and element count widths follow from the depth.
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   rsp_ctl_type       rsp_ctl;
   logic              out_free;

   // Output register: it parts the sink from the sequencer, so a new item can
   // be taken in the same cycle that a waiting result is taken away.
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [DATA_W-1:0]   rsp_value_ff,  rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff,   rsp_last_in;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   deq_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_value (req_chan.value_in),
      .req_ready (req_chan.ready),
      .out_free  (out_free),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rsp_ctl   (rsp_ctl)
   );

   deq_ram #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Value is the store's read data for pops and dump elements, zero for
   // every status-only result.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_ctl.load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = rsp_ctl.from_mem ? rd_data : '0;
         rsp_status_in = rsp_ctl.status;
         rsp_last_in   = rsp_ctl.last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value_out = rsp_value_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule
